// ----- rtl/pews_pkg.sv -----
// Package for the parallel EEPROM write sequencer: types, codes and command tables.
// Used by the front end, the command queue, the phase sequencer and the top level.
`default_nettype none

package pews_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int Q_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_PAGE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK     = 2'd3;

    localparam logic [16:0] IMAGE_SIZE_RST = 17'd32768;
    localparam logic [15:0] PAGE_SIZE_RST  = 16'd64;

    localparam logic [1:0] HOLD_PULSE = 2'd0;
    localparam logic [1:0] HOLD_BYTE  = 2'd1;
    localparam logic [1:0] HOLD_PAGE  = 2'd2;

    localparam logic [15:0] SDP_ADDR_A = 16'h5555;
    localparam logic [15:0] SDP_ADDR_B = 16'h2AAA;
    localparam logic [7:0]  SDP_KEY_A  = 8'hAA;
    localparam logic [7:0]  SDP_KEY_B  = 8'h55;
    localparam logic [7:0]  SDP_ERASE  = 8'h80;
    localparam logic [7:0]  SDP_OFF    = 8'h20;
    localparam logic [7:0]  SDP_ON     = 8'hA0;

    typedef struct packed {
        logic [16:0] image_size;
        logic [15:0] page_size;
        logic        lock_each_page;
        logic        unlock_at_start;
    } t_cfg;

    // One classified input byte: which sequence segments it needs and its payload.
    typedef struct packed {
        logic        unlock;
        logic        page;
        logic        lock;
        logic        write;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        led;
        logic        last_byte;
    } t_desc;

    typedef struct packed {
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic        chip_enable_n;
        logic [1:0]  hold_kind;
        logic        led;
        logic        image_done;
        logic        last;
    } t_phase;

    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_UNLOCK,
        SEG_PAGE,
        SEG_LOCK,
        SEG_WRITE
    } t_seg;

    // Next segment the command needs, strictly after the current one.
    function automatic t_seg next_seg(input t_desc d, input t_seg cur);
        t_seg s;
        s = SEG_IDLE;
        case (cur)
            SEG_IDLE: begin
                if (d.unlock)      s = SEG_UNLOCK;
                else if (d.page)   s = SEG_PAGE;
                else if (d.lock)   s = SEG_LOCK;
                else if (d.write)  s = SEG_WRITE;
            end
            SEG_UNLOCK: begin
                if (d.page)        s = SEG_PAGE;
                else if (d.lock)   s = SEG_LOCK;
                else if (d.write)  s = SEG_WRITE;
            end
            SEG_PAGE: begin
                if (d.lock)        s = SEG_LOCK;
                else if (d.write)  s = SEG_WRITE;
            end
            SEG_LOCK: begin
                if (d.write)       s = SEG_WRITE;
            end
            default: s = SEG_IDLE;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] unlock_addr(input logic [2:0] w);
        logic [15:0] a;
        case (w)
            3'd1, 3'd4: a = SDP_ADDR_B;
            default:    a = SDP_ADDR_A;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] unlock_data(input logic [2:0] w);
        logic [7:0] v;
        case (w)
            3'd0, 3'd3: v = SDP_KEY_A;
            3'd1, 3'd4: v = SDP_KEY_B;
            3'd2:       v = SDP_ERASE;
            default:    v = SDP_OFF;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] lock_addr(input logic [2:0] w);
        logic [15:0] a;
        case (w)
            3'd1:    a = SDP_ADDR_B;
            default: a = SDP_ADDR_A;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] lock_data(input logic [2:0] w);
        logic [7:0] v;
        case (w)
            3'd0:    v = SDP_KEY_A;
            3'd1:    v = SDP_KEY_B;
            default: v = SDP_ON;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pews_in_if.sv -----
// Input channel of the sequencer: valid/ready plus one image byte and its marks.
// Stands alone; no package needed.
`default_nettype none

interface pews_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output byte_value, output first_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input byte_value, input first_byte, input last_byte,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/pews_out_if.sv -----
// Output channel of the sequencer: valid/ready plus one EEPROM bus phase.
// Stands alone; no package needed.
`default_nettype none

interface pews_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic        chip_enable_n;
    logic [1:0]  hold_kind;
    logic        led;
    logic        image_done;
    logic        last;

    modport source (output valid, output bus_address, output bus_data,
                    output chip_enable_n, output hold_kind, output led,
                    output image_done, output last, input ready);
    modport sink   (input valid, input bus_address, input bus_data,
                    input chip_enable_n, input hold_kind, input led,
                    input image_done, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pews_front.sv -----
// Front end: accepts image bytes, tracks address and page offset, and classifies
// each byte into a command for the queue. Depends on pews_pkg and pews_in_if.
`default_nettype none

module pews_front
    import pews_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pews_in_if.sink    i_byte,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_full,
    output logic       o_push,
    output t_desc      o_desc
);

    logic [16:0] r_next_address, n_next_address;
    logic [15:0] r_page_offset,  n_page_offset;
    logic [16:0] addr_base;
    logic [15:0] off_base;
    logic [15:0] off_inc;
    logic        in_range;
    logic        accept;

    assign i_byte.ready = !i_q_full;
    assign accept       = i_byte.valid && !i_q_full;

    always_comb begin
        addr_base = i_byte.first_byte ? 17'd0 : r_next_address;
        off_base  = i_byte.first_byte ? 16'd0 : r_page_offset;
        in_range  = (addr_base < i_cfg.image_size) && !addr_base[16];
        off_inc   = off_base + 16'd1;

        o_desc.unlock    = i_byte.first_byte && i_cfg.unlock_at_start;
        o_desc.page      = in_range && (i_cfg.page_size != 16'd0) && (off_base == 16'd0);
        o_desc.lock      = o_desc.page && i_cfg.lock_each_page;
        o_desc.write     = in_range;
        o_desc.addr      = addr_base[15:0];
        o_desc.data      = i_byte.byte_value;
        o_desc.led       = addr_base[8];
        o_desc.last_byte = i_byte.last_byte;

        n_next_address = in_range ? addr_base + 17'd1 : addr_base;
        if (!in_range) begin
            n_page_offset = off_base;
        end else if (i_cfg.page_size == 16'd0 || off_inc >= i_cfg.page_size) begin
            n_page_offset = 16'd0;
        end else begin
            n_page_offset = off_inc;
        end
    end

    // A dropped byte without an unlock sequence produces nothing downstream.
    assign o_push = accept && (o_desc.unlock || o_desc.write);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_address <= '0;
            r_page_offset  <= '0;
        end else if (accept) begin
            r_next_address <= n_next_address;
            r_page_offset  <= n_page_offset;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pews_queue.sv -----
// Short command queue between the front end and the phase sequencer.
// Depends on pews_pkg for the command type.
`default_nettype none

module pews_queue
    import pews_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output t_desc      o_head,
    output logic       o_empty,
    output logic       o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from an empty queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue fill count did not follow a push");

endmodule

`default_nettype wire

// ----- rtl/pews_back.sv -----
// Phase sequencer: walks each command's segments (unlock, page delay, lock, byte write)
// one bus phase per cycle unless held, to an output register. Needs pews_pkg, pews_out_if.
`default_nettype none

module pews_back
    import pews_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_desc i_head,
    input  wire logic  i_q_empty,
    output logic       o_pop,
    pews_out_if.source o_phase
);

    t_seg        r_state, n_state;
    t_desc       r_cur;
    logic [2:0]  r_word, n_word;
    logic [1:0]  r_sub,  n_sub;
    logic        r_out_valid;
    t_phase      r_out, phase;
    logic        advance;
    logic        seg_done;
    logic        final_phase;
    logic        fetch;

    assign advance = (r_state != SEG_IDLE) && (!r_out_valid || o_phase.ready);

    always_comb begin
        case (r_state)
            SEG_UNLOCK: seg_done = (r_word == 3'd6);
            SEG_PAGE:   seg_done = 1'b1;
            SEG_LOCK:   seg_done = (r_word == 3'd2) && (r_sub == 2'd2);
            SEG_WRITE:  seg_done = (r_sub == 2'd2);
            default:    seg_done = 1'b0;
        endcase
        final_phase = seg_done && (next_seg(r_cur, r_state) == SEG_IDLE);
        fetch       = !i_q_empty && ((r_state == SEG_IDLE) || (advance && final_phase));
    end

    // Next state and step counters.
    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        n_sub   = r_sub;
        if (fetch) begin
            n_state = next_seg(i_head, SEG_IDLE);
            n_word  = '0;
            n_sub   = '0;
        end else if (advance) begin
            if (seg_done) begin
                n_state = next_seg(r_cur, r_state);
                n_word  = '0;
                n_sub   = '0;
            end else if (r_sub == 2'd2) begin
                n_sub  = '0;
                n_word = r_word + 3'd1;
            end else begin
                n_sub = r_sub + 2'd1;
            end
        end
    end

    // Phase contents for the current step.
    always_comb begin
        phase.bus_address   = '0;
        phase.bus_data      = '0;
        phase.chip_enable_n = (r_sub != 2'd1);
        phase.hold_kind     = (r_sub == 2'd2) ? HOLD_BYTE : HOLD_PULSE;
        phase.led           = r_cur.led;
        phase.last          = final_phase;
        phase.image_done    = final_phase && r_cur.last_byte;
        case (r_state)
            SEG_UNLOCK: begin
                if (r_word == 3'd6) begin
                    phase.chip_enable_n = 1'b1;
                    phase.hold_kind     = HOLD_PAGE;
                end else begin
                    phase.bus_address = unlock_addr(r_word);
                    phase.bus_data    = unlock_data(r_word);
                end
            end
            SEG_PAGE: begin
                phase.chip_enable_n = 1'b1;
                phase.hold_kind     = HOLD_PAGE;
            end
            SEG_LOCK: begin
                phase.bus_address = lock_addr(r_word);
                phase.bus_data    = lock_data(r_word);
            end
            SEG_WRITE: begin
                phase.bus_address = r_cur.addr;
                phase.bus_data    = r_cur.data;
            end
            default: begin
                phase.chip_enable_n = 1'b1;
            end
        endcase
    end

    assign o_pop = fetch;

    always_ff @(posedge i_clk) begin
        if (fetch) begin
            r_cur <= i_head;
        end
        if (advance) begin
            r_out <= phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEG_IDLE;
            r_word      <= '0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            r_sub   <= n_sub;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_phase.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_phase.valid         = r_out_valid;
    assign o_phase.bus_address   = r_out.bus_address;
    assign o_phase.bus_data      = r_out.bus_data;
    assign o_phase.chip_enable_n = r_out.chip_enable_n;
    assign o_phase.hold_kind     = r_out.hold_kind;
    assign o_phase.led           = r_out.led;
    assign o_phase.image_done    = r_out.image_done;
    assign o_phase.last          = r_out.last;

    a_step_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd3) && (r_word <= 3'd6))
        else $error("phase step counter out of range");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_empty)
        else $error("sequencer fetched from an empty queue");

    a_fetch_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != SEG_IDLE) && (r_word == 3'd0) && (r_sub == 2'd0))
        else $error("fetched command did not start a segment");

endmodule

`default_nettype wire

// ----- rtl/parallel_eeprom_write_sequencer.sv -----
// A byte's command is queued, then loaded into the sequencer's command register, and each of its
// bus phases is registered in the output register, one per cycle unless the output is held.
// A plain byte is a write; a page start adds a page delay, locking a lock, unlocking an unlock.
// Reset (synchronous, active low) clears address, page offset, queue and output valid,
// and loads the configuration registers with their defaults.
`default_nettype none

// Top level of the parallel EEPROM write sequencer. It holds the configuration
// registers and joins the three parts:
//   - the front end takes image bytes, keeps the next address and page offset, and
//     turns each byte into a command that lists the segments it needs;
//   - a short command queue lets the front end take new bytes while phases of
//     earlier bytes are still being issued;
//   - the phase sequencer walks each command one bus phase per cycle into an
//     output register unless a phase is held; input stalls only once the queue fills.
// Depends on pews_pkg, pews_in_if, pews_out_if, pews_front, pews_queue and pews_back.
module parallel_eeprom_write_sequencer
    import pews_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    pews_in_if.sink                    i_byte,
    pews_out_if.source                 o_phase,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  push;
    logic  pop;
    logic  q_empty;
    logic  q_full;
    t_desc push_desc;
    t_desc head_desc;

    // Configuration writes take the low bits of the data word that each register needs.
    // The user must write them only while the block is idle; the block does not check. No shadowing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_size      <= IMAGE_SIZE_RST;
            r_cfg.page_size       <= PAGE_SIZE_RST;
            r_cfg.lock_each_page  <= 1'b0;
            r_cfg.unlock_at_start <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_SIZE: r_cfg.image_size      <= i_cfg_data[16:0];
                CFG_PAGE_SIZE:  r_cfg.page_size       <= i_cfg_data[15:0];
                CFG_LOCK_PAGE:  r_cfg.lock_each_page  <= i_cfg_data[0];
                CFG_UNLOCK:     r_cfg.unlock_at_start <= i_cfg_data[0];
                default:        r_cfg                 <= r_cfg;
            endcase
        end
    end

    // The front end accepts a beat whenever the queue has room. Dropped bytes that
    // need no unlock sequence are accepted and push nothing; a first one resets the address state.
    pews_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_cfg   (r_cfg),
        .i_q_full(q_full),
        .o_push  (push),
        .o_desc  (push_desc)
    );

    pews_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_head  (head_desc),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The sequencer picks the next command up on the same cycle that it issues the
    // final phase of the current one, so consecutive bytes leave no gap on the bus.
    pews_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head_desc),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_phase   (o_phase)
    );

endmodule

`default_nettype wire
